### design/efc_pkg.sv
package efc_pkg;

   // Field widths of the sample path and the coefficient path.
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = SAMPLE_BITS - 3;
   localparam int MAG_BITS = SAMPLE_BITS - 1;
   localparam int GAIN_BITS = COEF_BITS + 1;
   localparam int RATIO_BITS = COEF_BITS + 1;
   localparam int MAKEUP_BITS = 16;
   localparam int MAKEUP_FRAC = 14;

   // Widths of the intermediate products and of the divider step counter.
   localparam int ACC_BITS = MAG_BITS + GAIN_BITS;
   localparam int NUM_BITS = MAG_BITS + COEF_BITS;
   localparam int T_BITS = SAMPLE_BITS;
   localparam int M_BITS = SAMPLE_BITS + MAKEUP_BITS - MAKEUP_FRAC;
   localparam int STEP_BITS = $clog2(GAIN_BITS + 1);

   // The configuration data port is as wide as the widest register.
   localparam int CFG_WIDE_BITS = (MAG_BITS > COEF_BITS) ? MAG_BITS : COEF_BITS;
   localparam int CSR_DATA_BITS = (CFG_WIDE_BITS > MAKEUP_BITS) ? CFG_WIDE_BITS : MAKEUP_BITS;

   // Unity gain, rounding constants and the envelope floor.
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << COEF_BITS;
   localparam logic [ACC_BITS-1:0] COEF_HALF = ACC_BITS'(1) << (COEF_BITS - 1);
   localparam logic [T_BITS+GAIN_BITS-1:0] T_HALF = (T_BITS + GAIN_BITS)'(1) << (COEF_BITS - 1);
   localparam logic [T_BITS+MAKEUP_BITS-1:0] M_HALF =
      (T_BITS + MAKEUP_BITS)'(1) << (MAKEUP_FRAC - 1);
   localparam logic [MAG_BITS-1:0] ENV_FLOOR = MAG_BITS'((64'(1) << FRAC_BITS) / 10000);

   // Register reset values.
   localparam logic [COEF_BITS-1:0] ATTACK_RESET = COEF_BITS'(52241);
   localparam logic [COEF_BITS-1:0] RELEASE_RESET = COEF_BITS'(65387);
   localparam logic [MAG_BITS-1:0] KNEE_RESET = MAG_BITS'(1614807);
   localparam logic [MAKEUP_BITS-1:0] MAKEUP_RESET = MAKEUP_BITS'(16384);

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_ATTACK,
      CSR_RELEASE,
      CSR_KNEE,
      CSR_MAKEUP
   } csr_index_type;

   typedef struct packed {
      logic [COEF_BITS-1:0]   attack_coef;
      logic [COEF_BITS-1:0]   release_coef;
      logic [MAG_BITS-1:0]    knee_threshold;
      logic [MAKEUP_BITS-1:0] makeup_gain;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic env_mul;
      logic env_upd;
      logic gain_prep;
      logic div_start;
      logic div_take;
      logic mul_t;
      logic mul_m;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic compress;
      logic div_done;
      logic out_free;
   } ctrl_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV_MUL,
      ST_ENV_UPD,
      ST_GAIN_PREP,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_MUL_T,
      ST_MUL_M,
      ST_OUTPUT
   } ctrl_state_type;

endpackage

### design/envelope_follower_compressor.sv
// Feed-forward compressor with an envelope follower, one sample per item.
// Input channel req_: req_valid with req_sample_in and req_ratio_amount; an
// item is taken at a clock edge where req_valid is high and req_stall is low.
// Result channel rsp_: rsp_valid with rsp_sample_out; the receiver holds
// rsp_stall high to keep a result waiting in the output register.
// Configuration port csr_: csr_index selects attack, release, knee threshold
// or makeup gain; csr_data is written when csr_valid and csr_ready are high.
// Write it only while no item is in flight.
// An item passes through the envelope update and, when the envelope is above
// the knee and the floor, a division for the gain, then the gain and makeup
// products. A new item is taken only once the last result is in the output
// register. The restoring divider produces one quotient bit per cycle.
// A stalled result does not block the next item: it is accepted and worked
// on, and it waits at the output stage until the register is free.
// Reset clears the envelope to zero, loads the register defaults and empties
// the output register; no item is taken during reset.
module envelope_follower_compressor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [efc_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic [efc_pkg::RATIO_BITS-1:0]         req_ratio_amount,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [efc_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [efc_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import efc_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Configuration registers, each taking the low bits of the write data.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ATTACK:  cfg_in.attack_coef = csr_data[COEF_BITS-1:0];
            CSR_RELEASE: cfg_in.release_coef = csr_data[COEF_BITS-1:0];
            CSR_KNEE:    cfg_in.knee_threshold = csr_data[MAG_BITS-1:0];
            CSR_MAKEUP:  cfg_in.makeup_gain = csr_data[MAKEUP_BITS-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coef <= ATTACK_RESET;
         cfg_ff.release_coef <= RELEASE_RESET;
         cfg_ff.knee_threshold <= KNEE_RESET;
         cfg_ff.makeup_gain <= MAKEUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   efc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   efc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .status         (status),
      .sample_in      (req_sample_in),
      .ratio_amount   (req_ratio_amount),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

### design/efc_divider.sv
module efc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [efc_pkg::NUM_BITS-1:0]      numerator,
   input  logic [efc_pkg::MAG_BITS-1:0]      denominator,
   output logic                              done,
   output logic [efc_pkg::GAIN_BITS-1:0]     quotient
);
   import efc_pkg::*;

   logic [MAG_BITS-1:0]  rem_ff, rem_in;
   logic [MAG_BITS-1:0]  den_ff, den_in;
   logic [GAIN_BITS-1:0] low_ff, low_in;
   logic [GAIN_BITS-1:0] quo_ff, quo_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [MAG_BITS:0]    trial;
   logic [MAG_BITS:0]    trial_diff;

   // One restoring step per cycle. The quotient is known to fit GAIN_BITS,
   // so the upper numerator bits are already below the divisor at the start.
   always_comb begin
      trial = {rem_ff, low_ff[GAIN_BITS-1]};
      trial_diff = trial - {1'b0, den_ff};
      rem_in = rem_ff;
      den_in = den_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, numerator[NUM_BITS-1:GAIN_BITS]};
         low_in = numerator[GAIN_BITS-1:0];
         den_in = denominator;
         quo_in = '0;
         cnt_in = STEP_BITS'(GAIN_BITS);
      end else if (cnt_ff != '0) begin
         low_in = {low_ff[GAIN_BITS-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial_diff[MAG_BITS-1:0];
            quo_in = {quo_ff[GAIN_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[MAG_BITS-1:0];
            quo_in = {quo_ff[GAIN_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_BITS'(1);
         done_in = (cnt_ff == STEP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

   // The short form of the division needs the upper numerator below the divisor.
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      start |-> ({1'b0, numerator[NUM_BITS-1:GAIN_BITS]} < denominator))
      else $error("divider started with a quotient that does not fit");

   // A finished division leaves a remainder below the divisor.
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

### design/efc_datapath.sv
module efc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  efc_pkg::cfg_type                     cfg,
   input  efc_pkg::ctrl_cmd_type                cmd,
   output efc_pkg::ctrl_status_type             status,
   input  logic signed [efc_pkg::SAMPLE_BITS-1:0] sample_in,
   input  logic [efc_pkg::RATIO_BITS-1:0]       ratio_amount,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [efc_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);
   import efc_pkg::*;

   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic [MAG_BITS-1:0]    level_ff, level_in;
   logic                   neg_ff, neg_in;
   logic [GAIN_BITS-1:0]   one_minus_ratio_ff, one_minus_ratio_in;
   logic [MAG_BITS-1:0]    env_ff, env_in;
   logic [COEF_BITS-1:0]   coef_ff, coef_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [NUM_BITS-1:0]    num_ff, num_in;
   logic                   compress_ff, compress_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [T_BITS-1:0]      t_ff, t_in;
   logic [M_BITS-1:0]      m_ff, m_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_out_ff, rsp_out_in;

   logic [SAMPLE_BITS-1:0]          raw;
   logic                            raw_neg;
   logic [SAMPLE_BITS-1:0]          raw_mag;
   logic [GAIN_BITS-1:0]            ratio_sat;
   logic [COEF_BITS-1:0]            coef_sel;
   logic [GAIN_BITS-1:0]            one_minus_coef;
   logic [ACC_BITS-1:0]             level_prod;
   logic [ACC_BITS-1:0]             env_prod;
   logic [ACC_BITS-1:0]             env_sum;
   logic [MAG_BITS-1:0]             excess;
   logic [ACC_BITS-1:0]             excess_prod;
   logic [NUM_BITS-1:0]             knee_shift;
   logic [T_BITS+GAIN_BITS-1:0]     t_sum;
   logic [T_BITS+MAKEUP_BITS-1:0]   m_sum;
   logic                            sat_pos;
   logic                            sat_neg;
   logic [SAMPLE_BITS-1:0]          out_value;
   logic                            div_done;
   logic [GAIN_BITS-1:0]            div_quotient;

   efc_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (num_ff),
      .denominator (env_ff),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   // Magnitude of the incoming sample and the saturated ratio.
   always_comb begin
      raw = sample_in;
      raw_neg = raw[SAMPLE_BITS-1];
      raw_mag = raw_neg ? (SAMPLE_BITS'(0) - raw) : raw;
      ratio_sat = (ratio_amount > GAIN_ONE) ? GAIN_ONE : ratio_amount;
   end

   // Envelope follower terms: the coefficient is chosen on the old envelope.
   always_comb begin
      coef_sel = (level_ff > env_ff) ? cfg.attack_coef : cfg.release_coef;
      one_minus_coef = GAIN_ONE - {1'b0, coef_sel};
      level_prod = level_ff * one_minus_coef;
      env_prod = env_ff * coef_ff;
      env_sum = acc_ff + env_prod + COEF_HALF;
   end

   // Numerator of the gain and the compression condition.
   always_comb begin
      excess = env_ff - cfg.knee_threshold;
      excess_prod = excess * one_minus_ratio_ff;
      knee_shift = {cfg.knee_threshold, {COEF_BITS{1'b0}}};
      compress_in = (env_ff > cfg.knee_threshold) && (env_ff > ENV_FLOOR);
   end

   // Gain on the magnitude, then makeup, each rounded to nearest.
   always_comb begin
      t_sum = mag_ff * gain_ff + T_HALF;
      m_sum = t_ff * cfg.makeup_gain + M_HALF;
   end

   // Restore the sign and saturate to the sample range.
   always_comb begin
      sat_pos = |m_ff[M_BITS-1:SAMPLE_BITS-1];
      sat_neg = (|m_ff[M_BITS-1:SAMPLE_BITS])
                || (m_ff[SAMPLE_BITS-1] && (|m_ff[SAMPLE_BITS-2:0]));
      if (neg_ff) begin
         if (sat_neg) begin
            out_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end else begin
            out_value = SAMPLE_BITS'(0) - m_ff[SAMPLE_BITS-1:0];
         end
      end else begin
         if (sat_pos) begin
            out_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         end else begin
            out_value = m_ff[SAMPLE_BITS-1:0];
         end
      end
   end

   // Next values of the datapath registers under the controller's commands.
   always_comb begin
      mag_in = mag_ff;
      level_in = level_ff;
      neg_in = neg_ff;
      one_minus_ratio_in = one_minus_ratio_ff;
      env_in = env_ff;
      coef_in = coef_ff;
      acc_in = acc_ff;
      num_in = num_ff;
      gain_in = gain_ff;
      t_in = t_ff;
      m_in = m_ff;
      rsp_out_in = rsp_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         mag_in = raw_mag;
         level_in = raw_mag[MAG_BITS] ? {MAG_BITS{1'b1}} : raw_mag[MAG_BITS-1:0];
         neg_in = raw_neg;
         one_minus_ratio_in = GAIN_ONE - ratio_sat;
      end
      if (cmd.env_mul) begin
         coef_in = coef_sel;
         acc_in = level_prod;
      end
      if (cmd.env_upd) begin
         env_in = env_sum[COEF_BITS +: MAG_BITS];
      end
      if (cmd.gain_prep) begin
         num_in = knee_shift + excess_prod[NUM_BITS-1:0];
         gain_in = GAIN_ONE;
      end
      if (cmd.div_take) begin
         gain_in = div_quotient;
      end
      if (cmd.mul_t) begin
         t_in = t_sum[COEF_BITS +: T_BITS];
      end
      if (cmd.mul_m) begin
         m_in = m_sum[MAKEUP_FRAC +: M_BITS];
      end
      if (cmd.out_load) begin
         rsp_out_in = out_value;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         env_ff <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      level_ff <= level_in;
      neg_ff <= neg_in;
      one_minus_ratio_ff <= one_minus_ratio_in;
      coef_ff <= coef_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      gain_ff <= gain_in;
      t_ff <= t_in;
      m_ff <= m_in;
      rsp_out_ff <= rsp_out_in;
      if (cmd.gain_prep) begin
         compress_ff <= compress_in;
      end
   end

   always_comb begin
      status.compress = compress_in;
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_out_ff;

   // A computed gain never exceeds unity.
   a_gain_le_one: assert property (@(posedge clock) disable iff (reset)
      cmd.div_take |=> (gain_ff <= GAIN_ONE))
      else $error("compressor gain above unity");

   // Without compression the product stage sees unity gain.
   a_gain_unity: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_t && !compress_ff) |-> (gain_ff == GAIN_ONE))
      else $error("gain not unity below the knee");

endmodule

### design/efc_ctrl.sv
module efc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  efc_pkg::ctrl_status_type   status,
   output efc_pkg::ctrl_cmd_type      cmd
);
   import efc_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence of one item through the datapath. The input stays stalled
   // during reset so that no item is taken then.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_ENV_MUL;
            end
         end
         ST_ENV_MUL: begin
            cmd.env_mul = 1'b1;
            state_in = ST_ENV_UPD;
         end
         ST_ENV_UPD: begin
            cmd.env_upd = 1'b1;
            state_in = ST_GAIN_PREP;
         end
         ST_GAIN_PREP: begin
            cmd.gain_prep = 1'b1;
            state_in = status.compress ? ST_DIV_LOAD : ST_MUL_T;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in = ST_MUL_T;
            end
         end
         ST_MUL_T: begin
            cmd.mul_t = 1'b1;
            state_in = ST_MUL_M;
         end
         ST_MUL_M: begin
            cmd.mul_m = 1'b1;
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A result is only written into a free output register.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten");

   // The divider only finishes while the controller waits for it.
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

endmodule
